// ===== sv/psev_pkg.sv =====
`default_nettype none

package psev_pkg;

  // Stack geometry. The count holds 0 through StackDepth, the address 0 through StackDepth-1.
  localparam int unsigned StackDepth = 16;
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DataW      = 32;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 40;

  // ASCII codes that the token scanner recognizes.
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_TOKEN = 3'd3,
    ST_COUNT = 3'd4,
    ST_OVER  = 3'd5
  } status_e;

endpackage

`default_nettype wire

// ===== sv/psev_ram.sv =====
`default_nettype none

module psev_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/postfix_stack_evaluator.sv =====
// Postfix expression evaluator, one ASCII character per input word.
// A plain character is taken while the sequencer is idle; a + - * or / token executes at its end,
// a / token in a 32-step restoring divider. After the final word the result is read from the
// stack bottom and registered once the output slot is free.
// Throughput is one word per cycle while idle; the operand stack lives in a RAM with a
// registered read, so operand fetch, execute and write-back run as a short sequence of their own.
// Reset (rst_ni low, asynchronous) empties the stack, clears the error and drops the result.
`default_nettype none

module postfix_stack_evaluator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  wire logic        s_axis_tlast_i,   // last character of the expression
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o    // [31:0] value, [34:32] status, [39:35] zero
);

  localparam int unsigned CountW = psev_pkg::CountW;
  localparam int unsigned AddrW  = psev_pkg::AddrW;
  localparam int unsigned DataW  = psev_pkg::DataW;

  // Sequencer states. Every token end is handled in the cycle of its delimiter or in FINISH;
  // operators then fetch both operands from the stack RAM, execute and write back.
  typedef enum logic [3:0] {
    S_IDLE, S_FINISH, S_RDB, S_RDA, S_EXEC, S_DIV, S_DIVEND, S_WB, S_FINRD, S_FINOUT
  } state_e;

  // What the token seen so far looks like.
  typedef enum logic [2:0] {
    PH_IDLE, PH_MINUS, PH_OP, PH_POS, PH_NEG, PH_BAD
  } phase_e;

  typedef enum logic [1:0] { OP_ADD, OP_SUB, OP_MUL, OP_DIV } op_e;

  state_e                  state_q, state_d;
  phase_e                  phase_q, phase_d;
  op_e                     op_q, op_d;          // operator of the token being scanned
  op_e                     opsel_q, opsel_d;    // operator being executed
  logic [DataW-1:0]        acc_q, acc_d;
  logic [CountW-1:0]       cnt_q, cnt_d;
  psev_pkg::status_e       err_q, err_d;
  logic                    last_q, last_d;
  logic [DataW-1:0]        b_q, b_d;
  logic [DataW-1:0]        res_q, res_d;
  logic [DataW-1:0]        quo_q, quo_d;
  logic [DataW-1:0]        rem_q, rem_d;
  logic [DataW-1:0]        dvs_q, dvs_d;
  logic                    neg_q, neg_d;
  logic [4:0]              dcnt_q, dcnt_d;
  logic                    m_valid_q, m_valid_d;
  logic [39:0]             m_data_q, m_data_d;

  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic [DataW-1:0]        ram_wdata;
  logic [AddrW-1:0]        ram_raddr;
  logic [DataW-1:0]        ram_rdata;

  logic                    accept;
  logic                    is_space;
  logic                    is_digit;
  logic [DataW-1:0]        digit_val;
  logic [DataW-1:0]        acc_next;
  logic                    fin_now;
  logic                    fin_last;
  state_e                  after_tok;
  logic [CountW-1:0]       cnt_m1;
  logic [CountW-1:0]       cnt_m2;
  logic [DataW:0]          rem_sh;
  logic [DataW:0]          rem_diff;
  logic                    slot_free;
  psev_pkg::status_e       fin_status;

  // The operand stack. Operands are fetched only below the count, and the bottom entry
  // read for the result is used only when the stack holds exactly one written value.
  psev_ram #(
    .Width (DataW),
    .Depth (psev_pkg::StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign slot_free       = !m_valid_q || m_axis_tready_i;

  assign is_space  = (s_axis_tdata_i == psev_pkg::CharSpace) ||
                     (s_axis_tdata_i inside {[psev_pkg::CharTab:psev_pkg::CharCr]});
  assign is_digit  = s_axis_tdata_i inside {[psev_pkg::CharZero:psev_pkg::CharNine]};
  // For '0' through '9' the low nibble is the digit value.
  assign digit_val = {{(DataW-4){1'b0}}, s_axis_tdata_i[3:0]};
  // Decimal accumulation as shift-and-add: acc * 10 + digit, wrapping at 32 bits.
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + digit_val;

  assign cnt_m1   = cnt_q - CountW'(1);
  assign cnt_m2   = cnt_q - CountW'(2);
  assign rem_sh   = {rem_q, quo_q[DataW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  // Final status: the first error wins, else the stack must hold exactly one value.
  always_comb begin
    fin_status = err_q;
    if (err_q == psev_pkg::ST_OK && cnt_q != CountW'(1)) begin
      fin_status = psev_pkg::ST_COUNT;
    end
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    op_d      = op_q;
    opsel_d   = opsel_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    last_d    = last_q;
    b_d       = b_q;
    res_d     = res_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    neg_d     = neg_q;
    dcnt_d    = dcnt_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_wdata = (phase_q == PH_NEG) ? (DataW'(0) - acc_q) : acc_q;
    ram_raddr = '0;
    fin_now   = 1'b0;
    fin_last  = last_q;
    after_tok = last_q ? S_FINRD : S_IDLE;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = s_axis_tlast_i;
          if (is_space) begin
            fin_now  = 1'b1;
            fin_last = s_axis_tlast_i;
          end else begin
            case (phase_q)
              PH_IDLE: begin
                if (s_axis_tdata_i == psev_pkg::CharPlus) begin
                  phase_d = PH_OP;
                  op_d    = OP_ADD;
                end else if (s_axis_tdata_i == psev_pkg::CharStar) begin
                  phase_d = PH_OP;
                  op_d    = OP_MUL;
                end else if (s_axis_tdata_i == psev_pkg::CharSlash) begin
                  phase_d = PH_OP;
                  op_d    = OP_DIV;
                end else if (s_axis_tdata_i == psev_pkg::CharMinus) begin
                  phase_d = PH_MINUS;
                end else if (is_digit) begin
                  phase_d = PH_POS;
                  acc_d   = digit_val;
                end else begin
                  phase_d = PH_BAD;
                end
              end
              PH_MINUS: begin
                if (is_digit) begin
                  phase_d = PH_NEG;
                  acc_d   = digit_val;
                end else begin
                  phase_d = PH_BAD;
                end
              end
              PH_POS, PH_NEG: begin
                if (is_digit) begin
                  acc_d = acc_next;
                end else begin
                  phase_d = PH_BAD;
                end
              end
              default: phase_d = PH_BAD;
            endcase
            // A token that ends on the last character is closed in the next cycle.
            if (s_axis_tlast_i) begin
              state_d = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        fin_now = 1'b1;
      end
      S_RDB: begin
        ram_raddr = cnt_m1[AddrW-1:0];
        state_d   = S_RDA;
      end
      S_RDA: begin
        ram_raddr = cnt_m2[AddrW-1:0];
        b_d       = ram_rdata;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        // ram_rdata now holds the lower operand.
        case (opsel_q)
          OP_ADD: begin
            res_d   = ram_rdata + b_q;
            state_d = S_WB;
          end
          OP_SUB: begin
            res_d   = ram_rdata - b_q;
            state_d = S_WB;
          end
          OP_MUL: begin
            res_d   = ram_rdata * b_q;
            state_d = S_WB;
          end
          default: begin
            if (b_q == '0) begin
              err_d   = psev_pkg::ST_DIV0;
              cnt_d   = cnt_m2;
              state_d = after_tok;
            end else begin
              // Divide magnitudes; the sign is put back at the end.
              quo_d   = ram_rdata[DataW-1] ? (DataW'(0) - ram_rdata) : ram_rdata;
              dvs_d   = b_q[DataW-1] ? (DataW'(0) - b_q) : b_q;
              rem_d   = '0;
              neg_d   = ram_rdata[DataW-1] ^ b_q[DataW-1];
              dcnt_d  = '0;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        // One restoring step per cycle; quotient bits shift in where dividend bits leave.
        if (!rem_diff[DataW]) begin
          rem_d = rem_diff[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = S_DIVEND;
        end
      end
      S_DIVEND: begin
        res_d   = neg_q ? (DataW'(0) - quo_q) : quo_q;
        state_d = S_WB;
      end
      S_WB: begin
        // Two operands popped, one result pushed: this can never overflow.
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[AddrW-1:0];
        ram_wdata = res_q;
        cnt_d     = cnt_m1;
        state_d   = after_tok;
      end
      S_FINRD: begin
        ram_raddr = '0;
        state_d   = S_FINOUT;
      end
      S_FINOUT: begin
        ram_raddr = '0;
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, fin_status,
                       (fin_status == psev_pkg::ST_OK) ? ram_rdata : DataW'(0)};
          cnt_d     = '0;
          err_d     = psev_pkg::ST_OK;
          last_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Token end: act on the scanned token unless an error is already held.
    if (fin_now) begin
      after_tok = fin_last ? S_FINRD : S_IDLE;
      state_d   = after_tok;
      phase_d   = PH_IDLE;
      acc_d     = '0;
      op_d      = OP_ADD;
      if (err_q == psev_pkg::ST_OK) begin
        case (phase_q)
          PH_MINUS, PH_OP: begin
            opsel_d = (phase_q == PH_MINUS) ? OP_SUB : op_q;
            if (cnt_q < CountW'(2)) begin
              err_d = psev_pkg::ST_FEW;
            end else begin
              state_d = S_RDB;
            end
          end
          PH_POS, PH_NEG: begin
            if (cnt_q >= CountW'(psev_pkg::StackDepth)) begin
              err_d = psev_pkg::ST_OVER;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CountW'(1);
            end
          end
          PH_BAD: err_d = psev_pkg::ST_TOKEN;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_IDLE;
      op_q      <= OP_ADD;
      opsel_q   <= OP_ADD;
      acc_q     <= '0;
      cnt_q     <= '0;
      err_q     <= psev_pkg::ST_OK;
      last_q    <= 1'b0;
      b_q       <= '0;
      res_q     <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      dvs_q     <= '0;
      neg_q     <= 1'b0;
      dcnt_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      op_q      <= op_d;
      opsel_q   <= opsel_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      last_q    <= last_d;
      b_q       <= b_d;
      res_q     <= res_d;
      quo_q     <= quo_d;
      rem_q     <= rem_d;
      dvs_q     <= dvs_d;
      neg_q     <= neg_d;
      dcnt_q    <= dcnt_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/psev_checker.sv =====
`default_nettype none

module psev_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o
);

  // A stalled result word keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result payload changed while stalled");

  // Any error status carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34:32] != psev_pkg::ST_OK |->
      m_axis_tdata_o[31:0] == 32'd0)
    else $error("nonzero value with an error status");

  // Status stays within its defined codes and the padding stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[34:32] != 3'd6 && m_axis_tdata_o[34:32] != 3'd7 &&
      m_axis_tdata_o[39:35] == 5'd0)
    else $error("undefined status code or padding set");

endmodule

bind postfix_stack_evaluator psev_checker u_psev_checker (.*);

`default_nettype wire

// ===== bench/postfix_stack_evaluator_test.sv =====
`timescale 1ns / 100ps

module postfix_stack_evaluator_test;

  // Scanner phases of the expected-value calculator, one per kind of partial token.
  typedef enum logic [2:0] {
    SCAN_GAP,
    SCAN_MINUS,
    SCAN_OPER,
    SCAN_POS,
    SCAN_NEG,
    SCAN_BAD
  } scan_e;

  // Arithmetic operators held while an operator token is still open.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } oper_e;

  // One character word waiting to be sent. The drain flag makes the sender wait until
  // every result already owed has come back before this word is offered.
  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       after_drain;
  } char_word_t;

  typedef struct {
    logic [31:0]       value;
    psev_pkg::status_e status;
  } result_t;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailWords  = 200;
  localparam int unsigned WordTarget = 1750;

  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [psev_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                          s_axis_tlast_i  = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [psev_pkg::OutDataW-1:0] m_axis_tdata_o;

  postfix_stack_evaluator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] char_code
    .s_axis_tlast_i  (s_axis_tlast_i),   // last character of the expression
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)    // [31:0] value, [34:32] status, [39:35] zero
  );

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is held at the start and never again.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Expected-value calculator. It keeps its own operand stack and scanner state and
  // is advanced once for every character word the block accepts.
  // ---------------------------------------------------------------------------
  logic [31:0]       eval_stack [psev_pkg::StackDepth];
  int unsigned       eval_depth  = 0;
  logic [31:0]       digit_acc   = '0;
  scan_e             scan_phase  = SCAN_GAP;
  oper_e             held_op     = OP_ADD;
  psev_pkg::status_e first_error = psev_pkg::ST_OK;

  result_t expected_results[$];

  // Signed division truncated toward zero, done on magnitudes. The most negative
  // value divided by minus one wraps back to itself.
  function automatic logic [31:0] trunc_quotient(logic [31:0] lhs, logic [31:0] rhs);
    logic [31:0] mag_l;
    logic [31:0] mag_r;
    logic [31:0] mag_q;
    mag_l = lhs[31] ? -lhs : lhs;
    mag_r = rhs[31] ? -rhs : rhs;
    mag_q = mag_l / mag_r;
    return (lhs[31] ^ rhs[31]) ? -mag_q : mag_q;
  endfunction

  function automatic void push_operand(logic [31:0] operand);
    if (eval_depth >= psev_pkg::StackDepth) begin
      first_error = psev_pkg::ST_OVER;
    end else begin
      eval_stack[eval_depth] = operand;
      eval_depth++;
    end
  endfunction

  function automatic void apply_oper(oper_e op);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    if (eval_depth < 2) begin
      first_error = psev_pkg::ST_FEW;
      return;
    end
    rhs = eval_stack[eval_depth - 1];
    lhs = eval_stack[eval_depth - 2];
    eval_depth -= 2;
    case (op)
      OP_ADD: res = lhs + rhs;
      OP_SUB: res = lhs - rhs;
      OP_MUL: res = lhs * rhs;
      default: begin
        if (rhs == '0) begin
          first_error = psev_pkg::ST_DIV0;
          return;
        end
        res = trunc_quotient(lhs, rhs);
      end
    endcase
    push_operand(res);
  endfunction

  // A token takes effect when it closes. Once an error is held, tokens are dropped.
  function automatic void close_token();
    if (first_error == psev_pkg::ST_OK) begin
      case (scan_phase)
        SCAN_MINUS: apply_oper(OP_SUB);
        SCAN_OPER:  apply_oper(held_op);
        SCAN_POS:   push_operand(digit_acc);
        SCAN_NEG:   push_operand(-digit_acc);
        SCAN_BAD:   first_error = psev_pkg::ST_TOKEN;
        default: ;
      endcase
    end
    scan_phase = SCAN_GAP;
    digit_acc  = '0;
    held_op    = OP_ADD;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic        is_digit;
    logic [31:0] digit_val;
    is_digit  = (c >= psev_pkg::CharZero) && (c <= psev_pkg::CharNine);
    digit_val = {24'd0, c - psev_pkg::CharZero};
    case (scan_phase)
      SCAN_GAP: begin
        if (c == psev_pkg::CharPlus) begin
          scan_phase = SCAN_OPER;
          held_op    = OP_ADD;
        end else if (c == psev_pkg::CharStar) begin
          scan_phase = SCAN_OPER;
          held_op    = OP_MUL;
        end else if (c == psev_pkg::CharSlash) begin
          scan_phase = SCAN_OPER;
          held_op    = OP_DIV;
        end else if (c == psev_pkg::CharMinus) begin
          scan_phase = SCAN_MINUS;
        end else if (is_digit) begin
          scan_phase = SCAN_POS;
          digit_acc  = digit_val;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_MINUS: begin
        if (is_digit) begin
          scan_phase = SCAN_NEG;
          digit_acc  = digit_val;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_POS, SCAN_NEG: begin
        if (is_digit) digit_acc = digit_acc * 32'd10 + digit_val;
        else scan_phase = SCAN_BAD;
      end
      default: scan_phase = SCAN_BAD;
    endcase
  endfunction

  // Advance the calculator by one accepted word; the last word of an expression
  // closes the open token, queues the expected result and clears all state.
  function automatic void predict_word(logic [7:0] c, logic is_last);
    result_t res;
    if (c == psev_pkg::CharSpace || (c >= psev_pkg::CharTab && c <= psev_pkg::CharCr))
      close_token();
    else scan_char(c);
    if (!is_last) return;
    close_token();
    res.status = first_error;
    if (res.status == psev_pkg::ST_OK && eval_depth != 1) res.status = psev_pkg::ST_COUNT;
    res.value = (res.status == psev_pkg::ST_OK) ? eval_stack[0] : '0;
    expected_results.push_back(res);
    eval_depth  = 0;
    first_error = psev_pkg::ST_OK;
  endfunction

  // ---------------------------------------------------------------------------
  // Expression text generation. Each expression is built in a byte buffer and then
  // moved into the queue of pending words, with the last flag on its final byte.
  // ---------------------------------------------------------------------------
  char_word_t  pending_chars[$];
  logic [7:0]  expr_text[$];
  int unsigned expr_count = 0;

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
  endtask

  // Mostly plain spaces, sometimes one of the other separators (tab through CR).
  task automatic add_blank();
    int unsigned runs;
    runs = $urandom_range(1, 3) == 1 ? 2 : 1;
    repeat (runs) begin
      if ($urandom_range(0, 2) != 0) expr_text.push_back(psev_pkg::CharSpace);
      else expr_text.push_back(psev_pkg::CharTab + 8'($urandom_range(0, 4)));
    end
  endtask

  task automatic add_number();
    int          v;
    int unsigned digits;
    case ($urandom_range(0, 5))
      0, 1: begin
        v = $urandom_range(0, 20);
        if ($urandom_range(0, 2) == 0) expr_text.push_back(psev_pkg::CharMinus);
        add_text($sformatf("%0d", v));
      end
      2: begin
        v = $urandom;
        add_text($sformatf("%0d", v));
      end
      3: begin
        // Boundary values, and digit strings that wrap past 32 bits.
        case ($urandom_range(0, 7))
          0: add_text("-2147483648");
          1: add_text("2147483647");
          2: add_text("4294967295");
          3: add_text("4294967296");
          4: add_text("-1");
          5: add_text("0");
          6: add_text("99999999999");
          default: add_text("-0");
        endcase
      end
      default: begin
        if ($urandom_range(0, 2) == 0) expr_text.push_back(psev_pkg::CharMinus);
        digits = $urandom_range(1, 14);
        repeat (digits) expr_text.push_back(psev_pkg::CharZero + 8'($urandom_range(0, 9)));
      end
    endcase
  endtask

  task automatic add_oper();
    case ($urandom_range(0, 4))
      0: expr_text.push_back(psev_pkg::CharPlus);
      1: expr_text.push_back(psev_pkg::CharMinus);
      2: expr_text.push_back(psev_pkg::CharStar);
      default: expr_text.push_back(psev_pkg::CharSlash);
    endcase
  endtask

  // Build a well-formed expression from a given number of operands. With numbers
  // first, every operand is pushed before any operator, which fills the stack.
  task automatic gen_wellformed(int unsigned operands, bit numbers_first);
    int unsigned live;
    int unsigned left;
    live = 0;
    left = operands;
    if ($urandom_range(0, 5) == 0) add_blank();
    while (left > 0 || live > 1) begin
      if (live >= 2 && (left == 0 || (!numbers_first && $urandom_range(0, 2) == 0))) begin
        add_oper();
        live--;
      end else if ($urandom_range(0, 14) == 0) begin
        // The one quotient that overflows: most negative value over minus one.
        add_text("-2147483648 -1 /");
        live++;
        left--;
      end else begin
        add_number();
        live++;
        left--;
      end
      if (left > 0 || live > 1) add_blank();
    end
    if ($urandom_range(0, 3) == 0) add_blank();
  endtask

  task automatic flush_expression();
    char_word_t w;
    expr_count++;
    foreach (expr_text[i]) begin
      w.code        = expr_text[i];
      w.last        = (i == expr_text.size() - 1);
      w.after_drain = (i == 0) && (expr_count % 40 == 0);
      pending_chars.push_back(w);
    end
    expr_text.delete();
  endtask

  task automatic gen_random_expression();
    int unsigned pick;
    int unsigned spot;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      gen_wellformed($urandom_range(1, 6), 1'b0);
    end else if (pick < 80) begin
      // Broken variants: a stray byte, a surplus operator or a surplus operand.
      gen_wellformed($urandom_range(1, 5), 1'b0);
      case ($urandom_range(0, 2))
        0: begin
          spot = $urandom_range(0, expr_text.size() - 1);
          expr_text[spot] = 8'($urandom_range(0, 255));
        end
        1: begin
          add_blank();
          add_oper();
        end
        default: begin
          add_blank();
          add_number();
        end
      endcase
    end else if (pick < 88) begin
      gen_wellformed($urandom_range(psev_pkg::StackDepth - 1, psev_pkg::StackDepth + 1), 1'b1);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 6)) expr_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_blank();
    end
    flush_expression();
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Offers words from the pending queue, idles in short random bursts,
  // pauses on a drain mark, and runs without gaps over the last stretch.
  // ---------------------------------------------------------------------------
  int unsigned words_taken   = 0;
  int unsigned lasts_sent    = 0;
  int unsigned results_seen  = 0;
  logic        tail_quiet    = 1'b0;
  int unsigned src_gap       = 0;
  logic        drive_valid;
  logic        word_taken;
  int unsigned owed_lasts;
  char_word_t  next_word;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = s_axis_tvalid_i && s_axis_tready_o;
      owed_lasts = lasts_sent;
      if (word_taken) begin
        predict_word(s_axis_tdata_i, s_axis_tlast_i);
        words_taken <= words_taken + 1;
        if (s_axis_tlast_i) begin
          owed_lasts  = lasts_sent + 1;
          lasts_sent <= lasts_sent + 1;
        end
      end
      tail_quiet <= (pending_chars.size() < TailWords);
      if (!s_axis_tvalid_i || word_taken) begin
        drive_valid = 1'b0;
        if (src_gap != 0) begin
          src_gap--;
        end else if (pending_chars.size() != 0) begin
          if (pending_chars[0].after_drain && owed_lasts != results_seen) begin
            // Hold back until the block has returned every result it owes.
          end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 3);
          end else begin
            next_word   = pending_chars.pop_front();
            drive_valid = 1'b1;
            s_axis_tdata_i <= next_word.code;
            s_axis_tlast_i <= next_word.last;
          end
        end
        s_axis_tvalid_i <= drive_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off. Once a few hundred words are in, the receiver refuses
  // results for a long stretch so that the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_taken >= 400) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker. Every accepted result is compared with the oldest
  // expectation; the first ten mismatches are reported in full.
  // ---------------------------------------------------------------------------
  int unsigned mismatch_count = 0;
  int unsigned sink_gap       = 0;
  logic        next_ready;
  result_t     want;
  logic [31:0] got_value;
  logic [2:0]  got_status;

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen <= results_seen + 1;
        got_value  = m_axis_tdata_o[31:0];
        got_status = m_axis_tdata_o[34:32];
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result with none expected: value %0d status %0d",
                                  $signed(got_value), got_status));
        end else begin
          want = expected_results.pop_front();
          if (got_value !== want.value)
            note_mismatch($sformatf("value expected %0d actual %0d",
                                    $signed(want.value), $signed(got_value)));
          if (got_status !== want.status)
            note_mismatch($sformatf("status expected %0d actual %0d",
                                    want.status, got_status));
          if (m_axis_tdata_o[psev_pkg::OutDataW-1:35] !== '0)
            note_mismatch($sformatf("padding expected 0 actual %h",
                                    m_axis_tdata_o[psev_pkg::OutDataW-1:35]));
        end
      end
      if (hold_left != 0) begin
        next_ready = 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        next_ready = 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
        sink_gap   = $urandom_range(0, 3);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready_i <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles without any word moving on either side ends the run.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed opening: an empty expression, a number closed by the last word,
    // minus as subtraction, division by zero, minus before a non-digit, too few
    // operands, the top and bottom byte values, and a wrong final count.
    add_text(" ");
    flush_expression();
    add_text("7");
    flush_expression();
    add_text("5 3 -");
    flush_expression();
    add_text("-8 0 /");
    flush_expression();
    add_text("-x");
    flush_expression();
    add_text("2 *");
    flush_expression();
    expr_text.push_back(8'hFF);
    flush_expression();
    expr_text.push_back(8'h00);
    flush_expression();
    add_text("1 2");
    flush_expression();

    while (pending_chars.size() < WordTarget) gen_random_expression();

    while (pending_chars.size() != 0 || s_axis_tvalid_i !== 1'b0) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/psev_pkg.sv
sv/psev_ram.sv
sv/postfix_stack_evaluator.sv
sv/psev_checker.sv
bench/postfix_stack_evaluator_test.sv
